@@ rtl/core/mms_pkg.sv @@
// Package for the min/max stack: depth, widths, operation codes and the
// layout of one stored slot. No dependencies.
package mms_pkg;

    localparam int STACK_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int WORD_W      = 32;
    localparam int ANS_W       = WORD_W + 1;

    // Operation codes
    localparam logic [2:0] OP_PUSH = 3'd0;
    localparam logic [2:0] OP_POP  = 3'd1;
    localparam logic [2:0] OP_TOP  = 3'd2;
    localparam logic [2:0] OP_MAX  = 3'd3;
    localparam logic [2:0] OP_MIN  = 3'd4;
    localparam logic [2:0] OP_DIFF = 3'd5;

    // One stack level: the word and the running extremes down to the bottom
    typedef struct packed {
        logic signed [WORD_W-1:0] value;
        logic signed [WORD_W-1:0] run_max;
        logic signed [WORD_W-1:0] run_min;
    } mms_slot_t;

    localparam int SLOT_W = $bits(mms_slot_t);

    // Port of the slot memory as driven by the core
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        mms_slot_t         wdata;
        logic [ADDR_W-1:0] raddr;
    } mms_ram_req_t;

endpackage

@@ rtl/core/mms_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module mms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/mms_core.sv @@
// Stack control: fill count, cached top slot, push/pop/query handling.
// Depends on mms_pkg; drives the slot memory through mms_ram_req_t.
module mms_core
    import mms_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [2:0]               op,
    input  logic signed [WORD_W-1:0] value,
    output mms_ram_req_t             ram_req,
    input  mms_slot_t                ram_rdata,
    output logic                     done,
    output logic signed [ANS_W-1:0]  answer,
    output logic                     was_empty
);

    logic [CNT_W-1:0]        count_reg, count_next;
    logic                    reload_reg, reload_next;
    mms_slot_t               cache_reg, cache_next;
    logic                    done_reg, done_next;
    logic signed [ANS_W-1:0] answer_reg, answer_next;
    logic                    empty_reg, empty_next;

    mms_slot_t               top_slot;
    mms_slot_t               push_slot;
    logic                    is_empty;
    logic                    is_full;
    logic [CNT_W-1:0]        below_idx;

    // Top slot: fresh memory data for one cycle after a pop that leaves a level, else the cache
    assign top_slot  = reload_reg ? ram_rdata : cache_reg;
    assign is_empty  = (count_reg == '0);
    assign is_full   = (count_reg == CNT_W'(STACK_DEPTH));
    assign below_idx = count_reg - CNT_W'(2);

    // Slot formed by a push
    always_comb
    begin
        push_slot.value   = value;
        push_slot.run_max = value;
        push_slot.run_min = value;
        if (!is_empty)
        begin
            if (top_slot.run_max > value)
            begin
                push_slot.run_max = top_slot.run_max;
            end
            if (top_slot.run_min < value)
            begin
                push_slot.run_min = top_slot.run_min;
            end
        end
    end

    // Request decode
    always_comb
    begin
        count_next    = count_reg;
        reload_next   = 1'b0;
        cache_next    = top_slot;
        done_next     = 1'b0;
        answer_next   = answer_reg;
        empty_next    = empty_reg;
        ram_req.we    = 1'b0;
        ram_req.waddr = count_reg[ADDR_W-1:0];
        ram_req.wdata = push_slot;
        ram_req.raddr = below_idx[ADDR_W-1:0];

        if (start)
        begin
            unique case (op)
                OP_PUSH:
                begin
                    if (!is_full)
                    begin
                        ram_req.we = 1'b1;
                        cache_next = push_slot;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                OP_POP:
                begin
                    if (!is_empty)
                    begin
                        count_next  = count_reg - CNT_W'(1);
                        // fetch the level below when one remains
                        reload_next = (count_reg > CNT_W'(1));
                    end
                end
                OP_TOP, OP_MAX, OP_MIN, OP_DIFF:
                begin
                    done_next  = 1'b1;
                    empty_next = is_empty;
                    if (is_empty)
                    begin
                        answer_next = '0;
                    end
                    else
                    begin
                        unique case (op)
                            OP_TOP:  answer_next = ANS_W'(top_slot.value);
                            OP_MAX:  answer_next = ANS_W'(top_slot.run_max);
                            OP_MIN:  answer_next = ANS_W'(top_slot.run_min);
                            default: answer_next = ANS_W'(top_slot.run_max)
                                                 - ANS_W'(top_slot.run_min);
                        endcase
                    end
                end
                default:
                begin
                    // unused codes: no effect
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            reload_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            reload_reg <= reload_next;
            done_reg   <= done_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        cache_reg  <= cache_next;
        answer_reg <= answer_next;
        empty_reg  <= empty_next;
    end

    assign done      = done_reg;
    assign answer    = answer_reg;
    assign was_empty = empty_reg;

endmodule

@@ rtl/core/min_max_stack.sv @@
// Min/max stack top level: one request per cycle, busy stays low.
// Results: a query's answer is registered and shows with done in the cycle after acceptance.
// Throughput: one request per cycle; the top slot is cached in registers and
// the level below is fetched from the slot memory during a pop.
// Reset: rst_n clears the fill count; memory contents are not cleared.
// The receiver cannot stall; each result shows for exactly one cycle.
module min_max_stack
    import mms_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [2:0]               op,
    input  logic signed [WORD_W-1:0] value,
    output logic                     done,
    output logic signed [ANS_W-1:0]  answer,
    output logic                     was_empty
);

    mms_ram_req_t     ram_req;
    logic [SLOT_W-1:0] ram_rdata;

    // Requests are never held off, so busy stays low
    assign busy = 1'b0;

    mms_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .op        (op),
        .value     (value),
        .ram_req   (ram_req),
        .ram_rdata (mms_slot_t'(ram_rdata)),
        .done      (done),
        .answer    (answer),
        .was_empty (was_empty)
    );

    // Slot memory: word and running extremes per level
    mms_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (SLOT_W'(ram_req.wdata)),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

endmodule

@@ tb/tb_top.sv @@
// Self-checking bench for min_max_stack: a queue-fed request driver, a result
// monitor and a bit-accurate stack model that predicts every query answer.
// Depends on mms_pkg and the min_max_stack RTL only.
module tb_top
    import mms_pkg::*;
();

    localparam int CLK_PERIOD  = 20;
    localparam int CYCLE_LIMIT = 100000;
    localparam int PRINT_CAP   = 40;

    // Op codes the block ignores
    localparam logic [2:0] OP_SPARE_A = 3'd6;
    localparam logic [2:0] OP_SPARE_B = 3'd7;

    localparam logic signed [WORD_W-1:0] WORD_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [WORD_W-1:0] WORD_MIN  = 32'sh8000_0000;
    localparam logic signed [WORD_W-1:0] WORD_ZERO = 32'sh0000_0000;
    localparam logic signed [WORD_W-1:0] WORD_ONES = 32'shFFFF_FFFF;

    typedef struct {
        logic [2:0]               op;
        logic signed [WORD_W-1:0] value;
        int unsigned              idle_pct;
        bit                       drain;     // hold off until all answers are in
    } stack_req_t;

    typedef struct {
        logic signed [ANS_W-1:0] answer;
        logic                    was_empty;
    } query_answer_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic [2:0] op = OP_PUSH;
    logic signed [WORD_W-1:0] value = '0;
    logic busy;
    logic done;
    logic signed [ANS_W-1:0] answer;
    logic was_empty;

    stack_req_t    pending_requests[$];
    query_answer_t expected_answers[$];

    // Model of the stack contents
    logic signed [WORD_W-1:0] model_word [STACK_DEPTH];
    logic signed [WORD_W-1:0] model_max  [STACK_DEPTH];
    logic signed [WORD_W-1:0] model_min  [STACK_DEPTH];
    int model_fill = 0;

    int          gen_fill = 0;
    int unsigned gen_idle_pct = 0;
    int          mismatch_count = 0;
    int          cycle_count = 0;

    stack_req_t    drv_req;
    logic          drv_accept;
    query_answer_t mon_want;

    always #(CLK_PERIOD / 2) clk = ~clk;

    min_max_stack u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .op        (op),
        .value     (value),
        .done      (done),
        .answer    (answer),
        .was_empty (was_empty)
    );

    // Apply one accepted request to the model; queries add an expected answer
    task automatic model_stack_op(input logic [2:0] req_op,
                                  input logic signed [WORD_W-1:0] req_value);
        query_answer_t           res;
        logic signed [WORD_W-1:0] hi;
        logic signed [WORD_W-1:0] lo;
        logic signed [ANS_W-1:0]  top_hi;
        logic signed [ANS_W-1:0]  top_lo;
        case (req_op)
            OP_PUSH:
            begin
                // a push onto a full stack is dropped
                if (model_fill < STACK_DEPTH)
                begin
                    hi = req_value;
                    lo = req_value;
                    if (model_fill > 0)
                    begin
                        if (model_max[model_fill-1] > hi)
                            hi = model_max[model_fill-1];
                        if (model_min[model_fill-1] < lo)
                            lo = model_min[model_fill-1];
                    end
                    model_word[model_fill] = req_value;
                    model_max[model_fill]  = hi;
                    model_min[model_fill]  = lo;
                    model_fill++;
                end
            end
            OP_POP:
            begin
                if (model_fill > 0)
                    model_fill--;
            end
            OP_TOP, OP_MAX, OP_MIN, OP_DIFF:
            begin
                res.was_empty = (model_fill == 0);
                res.answer    = '0;
                if (model_fill > 0)
                begin
                    top_hi = model_max[model_fill-1];   // sign-extended to 33 bits
                    top_lo = model_min[model_fill-1];
                    case (req_op)
                        OP_TOP:  res.answer = model_word[model_fill-1];
                        OP_MAX:  res.answer = top_hi;
                        OP_MIN:  res.answer = top_lo;
                        default: res.answer = top_hi - top_lo;
                    endcase
                end
                expected_answers.push_back(res);
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_CAP)
            $display("MISMATCH cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    // Stimulus helpers; gen_fill tracks the depth the queued requests will reach
    task automatic queue_request(input logic [2:0] req_op,
                                 input logic signed [WORD_W-1:0] req_value);
        stack_req_t req;
        req.op       = req_op;
        req.value    = req_value;
        req.idle_pct = gen_idle_pct;
        req.drain    = 1'b0;
        pending_requests.push_back(req);
        if (req_op == OP_PUSH && gen_fill < STACK_DEPTH)
            gen_fill++;
        else if (req_op == OP_POP && gen_fill > 0)
            gen_fill--;
    endtask

    task automatic queue_drain();
        stack_req_t req;
        req.op       = OP_POP;
        req.value    = '0;
        req.idle_pct = 0;
        req.drain    = 1'b1;
        pending_requests.push_back(req);
    endtask

    function automatic logic signed [WORD_W-1:0] pick_value();
        int unsigned sel;
        sel = $urandom_range(7);
        if (sel == 0)
        begin
            case ($urandom_range(3))
                0:       return WORD_MAX;
                1:       return WORD_MIN;
                2:       return WORD_ZERO;
                default: return WORD_ONES;
            endcase
        end
        // small values give plenty of ties on the running extremes
        if (sel == 1)
            return $signed(WORD_W'($urandom_range(16))) - 32'sd8;
        return $signed(WORD_W'($urandom));
    endfunction

    function automatic logic [2:0] pick_op(input int unsigned push_pct,
                                           input int unsigned pop_pct);
        int unsigned r;
        r = $urandom_range(99);
        if (r < push_pct)
            return OP_PUSH;
        if (r < push_pct + pop_pct)
            return OP_POP;
        if (r >= 98)
            return ($urandom_range(1) == 0) ? OP_SPARE_A : OP_SPARE_B;
        case ($urandom_range(3))
            0:       return OP_TOP;
            1:       return OP_MAX;
            2:       return OP_MIN;
            default: return OP_DIFF;
        endcase
    endfunction

    // Driver: presents requests from the pending queue, updates the model on accept
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            op    <= OP_PUSH;
            value <= '0;
        end
        else
        begin
            drv_accept = start && !busy;
            if (drv_accept)
                model_stack_op(op, value);
            if (!start || drv_accept)
            begin
                if (pending_requests.size() == 0)
                    start <= 1'b0;
                else if (pending_requests[0].drain)
                begin
                    start <= 1'b0;
                    if (expected_answers.size() == 0 && !done && !drv_accept)
                        void'(pending_requests.pop_front());
                end
                else if ($urandom_range(99) < pending_requests[0].idle_pct)
                    start <= 1'b0;
                else
                begin
                    drv_req = pending_requests.pop_front();
                    start <= 1'b1;
                    op    <= drv_req.op;
                    value <= drv_req.value;
                end
            end
        end
    end

    // Monitor: each strobed answer against the oldest outstanding query
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_answers.size() == 0)
                report_mismatch("answer strobed with no query outstanding");
            else
            begin
                mon_want = expected_answers.pop_front();
                if (answer !== mon_want.answer)
                    report_mismatch($sformatf("answer %0d, expected %0d",
                                              answer, mon_want.answer));
                if (was_empty !== mon_want.was_empty)
                    report_mismatch($sformatf("was_empty %0b, expected %0b",
                                              was_empty, mon_want.was_empty));
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("** min_max_stack: FAILED **");
            $finish;
        end
    end

    initial
    begin
        // Directed: empty stack, ignored codes, extreme words, ties and unwinding
        gen_idle_pct = 12;
        queue_request(OP_TOP, pick_value());
        queue_request(OP_MAX, pick_value());
        queue_request(OP_MIN, pick_value());
        queue_request(OP_DIFF, pick_value());
        queue_request(OP_POP, pick_value());
        queue_request(OP_SPARE_A, pick_value());
        queue_request(OP_SPARE_B, pick_value());
        queue_request(OP_PUSH, WORD_MAX);
        queue_request(OP_PUSH, WORD_MIN);
        queue_request(OP_DIFF, WORD_ZERO);
        queue_request(OP_MAX, WORD_ZERO);
        queue_request(OP_MIN, WORD_ZERO);
        queue_request(OP_TOP, WORD_ZERO);
        queue_request(OP_POP, WORD_ZERO);
        queue_request(OP_MIN, WORD_ZERO);
        queue_request(OP_DIFF, WORD_ZERO);
        queue_request(OP_PUSH, WORD_ZERO);
        queue_request(OP_PUSH, WORD_ONES);
        queue_request(OP_PUSH, WORD_ONES);
        queue_request(OP_DIFF, WORD_ZERO);
        queue_request(OP_POP, WORD_ZERO);
        queue_request(OP_POP, WORD_ZERO);
        queue_request(OP_POP, WORD_ZERO);
        queue_request(OP_TOP, WORD_ZERO);
        queue_drain();

        // Shallow mixed traffic, sender idles now and then
        for (int i = 0; i < 100; i++)
        begin
            queue_request(pick_op((gen_fill < 4) ? 50 : 35, 30), pick_value());
            if (i % 80 == 79)
                queue_drain();
        end

        // Climb to a full stack with a sparse sender, then push past the top
        gen_idle_pct = 64;
        while (gen_fill < STACK_DEPTH)
            queue_request(pick_op(90, 2), pick_value());
        for (int i = 0; i < 6; i++)
        begin
            queue_request(OP_PUSH, pick_value());
            queue_request(pick_op(0, 0), pick_value());
        end
        queue_drain();

        // Back-to-back requests, mostly unwinding through the stored levels
        gen_idle_pct = 0;
        for (int i = 0; i < 300; i++)
            queue_request(pick_op(20, 55), pick_value());

        // Hold reset for a while at the start, then release it
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        while (pending_requests.size() > 0 || start || expected_answers.size() > 0)
            @(negedge clk);
        repeat (4) @(negedge clk);

        if (mismatch_count == 0 && expected_answers.size() == 0)
            $display("** min_max_stack: PASSED **");
        else
            $display("** min_max_stack: FAILED **");
        $finish;
    end

endmodule
